>>> sv/assert_macros.svh
// Shared assertion macros for the sprite blitter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define SBT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset.
`define SBT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/sbt_pkg.sv
`default_nettype none
package sbt_pkg;

   // Frame-buffer geometry
   localparam int unsigned SCREEN_WIDTH = 320;
   localparam logic [15:0] BASE_LIMIT   = 16'd63679;
   localparam logic [7:0]  Y_LIMIT      = 8'd200;

   // Screen width at the width of the column sum (9-bit x plus 10-bit column)
   localparam logic [10:0] SCREEN_WIDTH_X = 11'(SCREEN_WIDTH);
   localparam logic [15:0] SCREEN_WIDTH_A = 16'(SCREEN_WIDTH);

   // Register map indexes (byte address / 4)
   localparam logic [2:0] REG_POS_X         = 3'd0;
   localparam logic [2:0] REG_POS_Y         = 3'd1;
   localparam logic [2:0] REG_SPRITE_WIDTH  = 3'd2;
   localparam logic [2:0] REG_SPRITE_HEIGHT = 3'd3;
   localparam logic [2:0] REG_COLOR_OFFSET  = 3'd4;
   localparam logic [2:0] REG_MIRROR_SIGN   = 3'd5;

   localparam int unsigned CSR_ADDR_W = 5;

   // Mirror sign codes (2-bit two's complement)
   localparam logic [1:0] MIRROR_ZERO = 2'b00;
   localparam logic [1:0] MIRROR_FWD  = 2'b01;
   localparam logic [1:0] MIRROR_DBL  = 2'b10;
   localparam logic [1:0] MIRROR_REV  = 2'b11;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic [8:0]  pos_x;
      logic [7:0]  pos_y;
      logic [15:0] y_base;
      logic [9:0]  sprite_width;
      logic [9:0]  sprite_height;
      logic [7:0]  color_offset;
      logic [1:0]  mirror_sign;
   } cfg_type;

endpackage
`default_nettype wire

>>> sv/sbt_if.sv
`default_nettype none
interface sbt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel;
   logic       first_pixel;

   modport source (output valid, output pixel, output first_pixel, input ready);
   modport sink (input valid, input pixel, input first_pixel, output ready);
endinterface

interface sbt_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] write_addr;
   logic [7:0]  write_data;

   modport source (output valid, output write_addr, output write_data, input ready);
   modport sink (input valid, input write_addr, input write_data, output ready);
endinterface
`default_nettype wire

>>> sv/sprite_blit_transparent.sv
// Sprite blitter with a colour key for a 320-wide, 8-bit frame buffer. Sprite
// pixels enter on req_bus in row-major order, one transfer each; first_pixel
// restarts the column, row and row-base counters from the current registers.
// Every pixel that is not zero (transparent), lies inside the sprite and is
// not clipped at the right edge (x + column >= 320, whatever the mirror sign)
// leaves as one transfer on rsp_bus: address = row base + x + column * mirror
// sign (mod 2^16), data = pixel + colour offset (mod 256). Other pixels give
// no transfer. With x > 320 or y > 200 nothing is drawn and the counters hold;
// once a row ends with the base at 63679 or more, or the last row is done, the
// rest of the sprite is dropped until the next first_pixel. Rate: one pixel
// per cycle while rsp_bus does not stall; pixels pass an input register
// and a result register. The rate is set by the counter and row-base update,
// which is combinational between those two registers. Write the registers
// over the APB port only while no pixel is in flight.
`default_nettype none
module sprite_blit_transparent (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // pixel stream in, write commands out
   sbt_req_if.sink                             req_bus,
   sbt_rsp_if.source                           rsp_bus,
   // register port
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [sbt_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                    pwdata,
   output logic      [31:0]                    prdata,
   output logic                                pready
);
   import sbt_pkg::*;

   // live configuration, including the precomputed top-row base
   cfg_type cfg;

   // register file: decode APB writes, serve reads
   sbt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // pixel datapath: input register, counter update, result register
   sbt_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

endmodule
`default_nettype wire

>>> sv/sbt_csr.sv
`default_nettype none
module sbt_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [sbt_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                    pwdata,
   output logic      [31:0]                    prdata,
   output logic                                pready,
   output sbt_pkg::cfg_type                    cfg
);
   import sbt_pkg::*;

   logic [8:0]  pos_x_ff;
   logic [7:0]  pos_y_ff;
   logic [15:0] y_base_ff;
   logic [9:0]  width_ff;
   logic [9:0]  height_ff;
   logic [7:0]  offset_ff;
   logic [1:0]  mirror_ff;
   logic [2:0]  index;
   logic        write_en;

   assign pready   = 1'b1;
   assign index    = paddr[CSR_ADDR_W-1:2];
   assign write_en = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff  <= '0;
         pos_y_ff  <= '0;
         y_base_ff <= '0;
         width_ff  <= '0;
         height_ff <= '0;
         offset_ff <= '0;
         mirror_ff <= MIRROR_FWD;
      end else if (write_en) begin
         case (index)
            REG_POS_X:         pos_x_ff <= pwdata[8:0];
            REG_POS_Y: begin
               pos_y_ff  <= pwdata[7:0];
               // precompute the top row base so the datapath needs no multiplier
               y_base_ff <= 16'({8'd0, pwdata[7:0]} * SCREEN_WIDTH_A);
            end
            REG_SPRITE_WIDTH:  width_ff  <= pwdata[9:0];
            REG_SPRITE_HEIGHT: height_ff <= pwdata[9:0];
            REG_COLOR_OFFSET:  offset_ff <= pwdata[7:0];
            REG_MIRROR_SIGN:   mirror_ff <= pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_POS_X:         prdata = {23'd0, pos_x_ff};
         REG_POS_Y:         prdata = {24'd0, pos_y_ff};
         REG_SPRITE_WIDTH:  prdata = {22'd0, width_ff};
         REG_SPRITE_HEIGHT: prdata = {22'd0, height_ff};
         REG_COLOR_OFFSET:  prdata = {24'd0, offset_ff};
         REG_MIRROR_SIGN:   prdata = {30'd0, mirror_ff};
         default:           prdata = '0;
      endcase
   end

   assign cfg.pos_x         = pos_x_ff;
   assign cfg.pos_y         = pos_y_ff;
   assign cfg.y_base        = y_base_ff;
   assign cfg.sprite_width  = width_ff;
   assign cfg.sprite_height = height_ff;
   assign cfg.color_offset  = offset_ff;
   assign cfg.mirror_sign   = mirror_ff;

endmodule
`default_nettype wire

>>> sv/sbt_core.sv
`default_nettype none
`include "assert_macros.svh"
module sbt_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  sbt_pkg::cfg_type cfg,
   sbt_req_if.sink         req_bus,
   sbt_rsp_if.source       rsp_bus
);
   import sbt_pkg::*;

   // input register
   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_pixel_ff;
   logic        s1_first_ff;

   // draw state
   logic [9:0]  col_ff, col_in;
   logic [9:0]  row_ff, row_in;
   logic [15:0] base_ff, base_in;
   logic        done_ff, done_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_addr_ff;
   logic [7:0]  rsp_data_ff;

   // state after an optional restart
   logic [9:0]  col_e;
   logic [9:0]  row_e;
   logic [15:0] base_e;
   logic        done_e;

   logic        adv;
   logic        pos_bad;
   logic        stop;
   logic        produce;
   logic [10:0] x_sum;
   logic [10:0] col_inc;
   logic [9:0]  row_inc;
   logic [15:0] col_ext;
   logic [15:0] col_off;
   logic [15:0] addr;

   // advance the input register whenever the result slot is free or drains
   assign adv           = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || adv;

   always_comb begin
      if (s1_first_ff) begin
         col_e  = '0;
         row_e  = '0;
         base_e = cfg.y_base;
         done_e = (cfg.sprite_width == '0) || (cfg.sprite_height == '0);
      end else begin
         col_e  = col_ff;
         row_e  = row_ff;
         base_e = base_ff;
         done_e = done_ff;
      end
   end

   assign pos_bad = ({2'b00, cfg.pos_x} > SCREEN_WIDTH_X) || (cfg.pos_y > Y_LIMIT);
   assign stop    = done_e || (col_e >= cfg.sprite_width) || (row_e >= cfg.sprite_height);
   assign x_sum   = {2'b00, cfg.pos_x} + {1'b0, col_e};
   assign produce = !pos_bad && !stop && (s1_pixel_ff != '0) && (x_sum < SCREEN_WIDTH_X);
   assign col_inc = {1'b0, col_e} + 11'd1;
   assign row_inc = row_e + 10'd1;
   assign col_ext = {6'd0, col_e};

   always_comb begin
      case (cfg.mirror_sign)
         MIRROR_FWD: col_off = col_ext;
         MIRROR_REV: col_off = 16'd0 - col_ext;
         MIRROR_DBL: col_off = 16'd0 - {col_ext[14:0], 1'b0};
         default:    col_off = '0;
      endcase
   end

   assign addr = base_e + {7'd0, cfg.pos_x} + col_off;

   always_comb begin
      col_in  = col_e;
      row_in  = row_e;
      base_in = base_e;
      done_in = done_e;
      if (pos_bad) begin
         // keep the restart, hold the counters
      end else if (stop) begin
         done_in = 1'b1;
      end else if ({1'b0, cfg.sprite_width} <= col_inc) begin
         col_in = '0;
         if (base_e < BASE_LIMIT) begin
            base_in = base_e + SCREEN_WIDTH_A;
            row_in  = row_inc;
            done_in = (row_inc >= cfg.sprite_height);
         end else begin
            done_in = 1'b1;
         end
      end else begin
         col_in = col_inc[9:0];
      end
   end

   always_comb begin
      if (req_bus.ready) begin
         s1_valid_in = req_bus.valid;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (adv) begin
         rsp_valid_in = produce;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         col_ff       <= '0;
         row_ff       <= '0;
         base_ff      <= '0;
         done_ff      <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (adv) begin
            col_ff  <= col_in;
            row_ff  <= row_in;
            base_ff <= base_in;
            done_ff <= done_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.ready) begin
         s1_pixel_ff <= req_bus.pixel;
         s1_first_ff <= req_bus.first_pixel;
      end
      if (adv && produce) begin
         rsp_addr_ff <= addr;
         rsp_data_ff <= s1_pixel_ff + cfg.color_offset;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.write_addr = rsp_addr_ff;
   assign rsp_bus.write_data = rsp_data_ff;

   `SBT_ASSERT_IMPLY(a_done_silent, clock, reset, s1_valid_ff && !s1_first_ff && done_ff, !produce, "finished draw produced a write")
   `SBT_ASSERT_IMPLY(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_bus.ready, !adv, "pending result overwritten")
   `SBT_ASSERT_NEXT(a_write_lands, clock, reset, adv && produce, rsp_valid_ff, "produced write not presented")

endmodule
`default_nettype wire

>>> tb/sv/sprite_blit_transparent_tb.sv
module sprite_blit_transparent_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sbt_pkg::*;

   // Generous ceiling on the whole run, above the slowest legal run: every pixel
   // waiting out the longest sender gap, every write waiting out the longest
   // receiver stall, plus the register traffic.
   localparam int unsigned CYCLE_LIMIT = 600000;
   // Cycles to let pass once the last expected write is in, before touching
   // the registers: covers the two-stage pipe plus margin.
   localparam int unsigned SETTLE_CYCLES = 4;
   // Pixels to send in the random part; the directed tests add under a hundred.
   localparam int unsigned RANDOM_ITEMS = 860;
   // Longest run of pixels sent for one sprite in the random part.
   localparam int unsigned MAX_SPRITE_PIXELS = 64;

   typedef struct packed {
      logic [15:0] addr;
      logic [7:0]  data;
   } fb_write_type;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   sbt_req_if req_bus ();
   sbt_rsp_if rsp_bus ();

   sprite_blit_transparent dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Frame-buffer writes still owed by the block, oldest first.
   fb_write_type pending_writes[$];
   int unsigned fail_count   = 0;
   int unsigned cycle_count  = 0;
   int unsigned sent_pixels  = 0;
   // Idling control shared by both sides: no_idle gives stretches with no gaps.
   bit          no_idle      = 1'b0;
   int unsigned rsp_gap      = 0;
   int unsigned rsp_hold_left = 0;

   // Our copy of the register file, at the register widths.
   logic [8:0]  set_x;
   logic [7:0]  set_y;
   logic [9:0]  set_w;
   logic [9:0]  set_h;
   logic [7:0]  set_offset;
   logic [1:0]  set_mirror;

   // Our copy of the sprite walk: column and row within the sprite, screen
   // address of the current row start, and whether the draw has ended.
   logic [9:0]  sprite_col;
   logic [9:0]  sprite_row;
   logic [15:0] line_base;
   logic        sprite_ended;

   // -------------------------------------------------------------------------
   // Clock, reset and the cycle limit
   // -------------------------------------------------------------------------
   initial clock = 1'b0;
   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Mismatch reporting: one line per failure, and every failure is counted.
   // -------------------------------------------------------------------------
   task automatic flag_mismatch(input string what);
      fail_count++;
      $display("[%0t] MISMATCH: %s", $time, what);
   endtask

   // -------------------------------------------------------------------------
   // Prediction of one pixel. Advances our sprite walk and returns 1 when the
   // pixel turns into a frame-buffer write.
   // -------------------------------------------------------------------------
   function automatic bit blit_pixel(input logic [7:0] pix, input logic first,
                                     output logic [15:0] addr,
                                     output logic [7:0] data);
      logic [15:0] step16;
      logic [31:0] col_offset;
      bit          hit;
      hit  = 1'b0;
      addr = '0;
      data = '0;
      // Restart: counters back to the sprite origin, empty sprites end at once.
      if (first) begin
         sprite_col   = '0;
         sprite_row   = '0;
         line_base    = 16'(set_y * SCREEN_WIDTH);
         sprite_ended = (set_w == 0) || (set_h == 0);
      end
      // Off-screen position: drop, and hold the counters.
      if (set_x > SCREEN_WIDTH || set_y > Y_LIMIT)
         return 1'b0;
      // Past the sprite or the base limit: drop until the next restart.
      if (sprite_ended || sprite_col >= set_w || sprite_row >= set_h) begin
         sprite_ended = 1'b1;
         return 1'b0;
      end
      // Mirror code as a 16-bit two's complement multiplier; the odd codes
      // (zero and minus two) multiply just the same.
      step16 = {{14{set_mirror[1]}}, set_mirror};
      // Transparent pixels and columns past the right edge write nothing;
      // the clip looks at x + column whatever the mirror does.
      if (pix != 8'd0 && (32'(set_x) + 32'(sprite_col)) < SCREEN_WIDTH) begin
         col_offset = 32'(sprite_col) * 32'(step16);
         addr = line_base + 16'(set_x) + col_offset[15:0];
         data = pix + set_offset;
         hit  = 1'b1;
      end
      sprite_col = sprite_col + 10'd1;
      if (sprite_col >= set_w) begin
         sprite_col = '0;
         if (line_base < BASE_LIMIT) begin
            line_base  = line_base + SCREEN_WIDTH_A;
            sprite_row = sprite_row + 10'd1;
            if (sprite_row >= set_h)
               sprite_ended = 1'b1;
         end else begin
            // Row ended too close to the top of the address space.
            sprite_ended = 1'b1;
         end
      end
      return hit;
   endfunction

   // -------------------------------------------------------------------------
   // Pixel side: one transfer per call, with a random gap ahead of it.
   // valid is left high after the transfer so back-to-back pixels never see
   // it drop; the next call lowers it when it has a gap, and wait_idle always does.
   // -------------------------------------------------------------------------
   task automatic send_pixel(input logic [7:0] pix, input logic first);
      int unsigned gap;
      logic [15:0] addr;
      logic [7:0]  data;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      @(negedge clock);
      if (gap != 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid       = 1'b1;
      req_bus.pixel       = pix;
      req_bus.first_pixel = first;
      do @(posedge clock); while (!req_bus.ready);
      if (blit_pixel(pix, first, addr, data))
         pending_writes.push_back('{addr: addr, data: data});
      sent_pixels++;
   endtask

   // Drop valid, wait for every owed write, then let the pipe empty of pixels
   // that give no write before any register is touched.
   task automatic wait_idle();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_writes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Write side: ready follows the hold-off first, then the per-transfer gap.
   // -------------------------------------------------------------------------
   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_bus.ready = 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_bus.ready = 1'b0;
      end else begin
         rsp_bus.ready = 1'b1;
      end
   end

   // Check every write transfer against the oldest owed write, field by field.
   always @(posedge clock) begin : check_writes
      fb_write_type owed;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_writes.size() == 0) begin
            flag_mismatch($sformatf("write with none owed: addr %h data %h",
                                    rsp_bus.write_addr, rsp_bus.write_data));
         end else begin
            owed = pending_writes.pop_front();
            if (rsp_bus.write_addr !== owed.addr)
               flag_mismatch($sformatf("write_addr %h, owed %h",
                                       rsp_bus.write_addr, owed.addr));
            if (rsp_bus.write_data !== owed.data)
               flag_mismatch($sformatf("write_data %h, owed %h (addr %h)",
                                       rsp_bus.write_data, owed.data, owed.addr));
         end
         rsp_gap = no_idle ? 0 : $urandom_range(0, 5);
      end
   end

   // -------------------------------------------------------------------------
   // Register port. Write one register (with junk above its width now and
   // then, which the block must ignore), update our copy, then read it back.
   // -------------------------------------------------------------------------
   task automatic write_csr(input logic [2:0] idx, input logic [31:0] value);
      int unsigned width;
      logic [31:0] field_mask;
      logic [31:0] stored;
      logic [31:0] rdata;
      case (idx)
         REG_POS_X:         width = 9;
         REG_POS_Y:         width = 8;
         REG_SPRITE_WIDTH:  width = 10;
         REG_SPRITE_HEIGHT: width = 10;
         REG_COLOR_OFFSET:  width = 8;
         default:           width = 2;
      endcase
      field_mask = (32'd1 << width) - 32'd1;
      stored     = value & field_mask;
      case (idx)
         REG_POS_X:         set_x      = stored[8:0];
         REG_POS_Y:         set_y      = stored[7:0];
         REG_SPRITE_WIDTH:  set_w      = stored[9:0];
         REG_SPRITE_HEIGHT: set_h      = stored[9:0];
         REG_COLOR_OFFSET:  set_offset = stored[7:0];
         default:           set_mirror = stored[1:0];
      endcase
      // setup, access
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {idx, 2'b00};
      pwdata  = ($urandom_range(0, 3) == 0) ? (stored | ($urandom() & ~field_mask))
                                             : stored;
      @(negedge clock);
      penable = 1'b1;
      // read back straight after
      @(negedge clock);
      penable = 1'b0;
      pwrite  = 1'b0;
      pwdata  = '0;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      rdata = prdata;
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      if ((rdata & field_mask) !== stored)
         flag_mismatch($sformatf("register %0d reads %h, written %h", idx,
                                 rdata & field_mask, stored));
   endtask

   // Settle the block, then load a whole sprite setting.
   task automatic set_sprite(input int unsigned x, input int unsigned y,
                             input int unsigned w, input int unsigned h,
                             input int unsigned offset, input logic [1:0] mirror);
      wait_idle();
      write_csr(REG_POS_X, 32'(x));
      write_csr(REG_POS_Y, 32'(y));
      write_csr(REG_SPRITE_WIDTH, 32'(w));
      write_csr(REG_SPRITE_HEIGHT, 32'(h));
      write_csr(REG_COLOR_OFFSET, 32'(offset));
      write_csr(REG_MIRROR_SIGN, 32'(mirror));
   endtask

   // -------------------------------------------------------------------------
   // Directed tests
   // -------------------------------------------------------------------------

   // Pixels with no restart since reset draw from a row base of zero.
   task automatic test_no_restart();
      set_sprite(5, 0, 3, 1, 0, MIRROR_FWD);
      send_pixel(8'd7, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd9, 1'b0);
   endtask

   // Full-scale pixels and offset: the data wraps at 256, zero stays unwritten.
   task automatic test_pixel_extremes();
      set_sprite(0, 0, 4, 1, 255, MIRROR_FWD);
      send_pixel(8'd255, 1'b1);
      send_pixel(8'd1, 1'b0);
      send_pixel(8'd0, 1'b0);
      send_pixel(8'd128, 1'b0);
   endtask

   // Mirrored walk from the left edge: the column steps below x and wraps.
   task automatic test_mirror();
      set_sprite(0, 3, 2, 2, 17, MIRROR_REV);
      send_pixel(8'd5, 1'b1);
      send_pixel(8'd6, 1'b0);
      send_pixel(8'd7, 1'b0);
      send_pixel(8'd8, 1'b0);
   endtask

   // Right-edge clip on the bottom allowed row; the extra pixel is dropped.
   task automatic test_right_clip();
      set_sprite(319, 200, 2, 1, 0, MIRROR_FWD);
      send_pixel(8'd3, 1'b1);
      send_pixel(8'd4, 1'b0);
      send_pixel(8'd5, 1'b0);
   endtask

   // Position past the screen in x, then in y: nothing drawn.
   task automatic test_out_of_range();
      set_sprite(321, 0, 2, 2, 0, MIRROR_FWD);
      send_pixel(8'd9, 1'b1);
      set_sprite(320, 201, 2, 2, 0, MIRROR_FWD);
      send_pixel(8'd9, 1'b1);
   endtask

   // Row base already past the limit: the first row ends the draw.
   task automatic test_base_limit();
      set_sprite(10, 199, 1, 3, 0, MIRROR_FWD);
      send_pixel(8'd1, 1'b1);
      send_pixel(8'd2, 1'b0);
      send_pixel(8'd3, 1'b0);
   endtask

   // Mirror codes minus two and zero act as plain multipliers.
   task automatic test_odd_mirror();
      set_sprite(100, 0, 2, 1, 0, MIRROR_DBL);
      send_pixel(8'd1, 1'b1);
      send_pixel(8'd2, 1'b0);
      set_sprite(100, 0, 2, 1, 0, MIRROR_ZERO);
      send_pixel(8'd1, 1'b1);
      send_pixel(8'd2, 1'b0);
   endtask

   // Zero-width sprite: the restart itself ends the draw.
   task automatic test_empty_sprite();
      set_sprite(0, 0, 0, 5, 0, MIRROR_FWD);
      send_pixel(8'd3, 1'b1);
   endtask

   // Hold the write side off for a long stretch while pixels keep coming,
   // so the block fills and has to stall its pixel input.
   task automatic test_backpressure();
      int unsigned i;
      set_sprite(20, 5, 8, 6, 3, MIRROR_FWD);
      no_idle       = 1'b1;
      rsp_hold_left = 80;
      for (i = 0; i < 48; i++)
         send_pixel(8'($urandom_range(1, 255)), i == 0);
      no_idle = 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Random sprites: mostly well-formed sprites with random content and
   // settings, some with a restart part-way, some trailing noise.
   // -------------------------------------------------------------------------
   task automatic test_random_sprites();
      int unsigned start_sent;
      int unsigned x, y, w, h, offset, n, cut, reps, extra, pick, i, r;
      logic [1:0]  mirror;
      bit          broken;
      logic [7:0]  pix;
      start_sent = sent_pixels;
      while (sent_pixels - start_sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 9);
         case (pick)
            0:       x = 0;
            1:       x = 320;
            2:       x = 319;
            3:       x = $urandom_range(321, 511);
            default: x = $urandom_range(0, 310);
         endcase
         pick = $urandom_range(0, 9);
         case (pick)
            0:       y = 0;
            1:       y = 200;
            2:       y = $urandom_range(190, 199);
            3:       y = $urandom_range(201, 255);
            default: y = $urandom_range(0, 180);
         endcase
         // Keep sprites small; only now and then go to the widest sizes.
         pick = $urandom_range(0, 39);
         case (pick)
            0: begin
               w = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
               h = (w == 0) ? $urandom_range(0, 4) : 0;
            end
            1: begin
               w = $urandom_range(512, 1023);
               h = $urandom_range(1, 2);
            end
            2: begin
               w = $urandom_range(1, 2);
               h = $urandom_range(512, 1023);
            end
            default: begin
               w = $urandom_range(1, 12);
               h = $urandom_range(1, 6);
            end
         endcase
         pick = $urandom_range(0, 7);
         case (pick)
            0:       offset = 0;
            1:       offset = 255;
            default: offset = $urandom_range(0, 255);
         endcase
         pick = $urandom_range(0, 7);
         case (pick)
            0:       mirror = MIRROR_ZERO;
            1:       mirror = MIRROR_DBL;
            2, 3, 4: mirror = MIRROR_REV;
            default: mirror = MIRROR_FWD;
         endcase
         set_sprite(x, y, w, h, offset, mirror);
         no_idle = ($urandom_range(0, 3) == 0);

         // Stray pixel before any restart under the new setting.
         if ($urandom_range(0, 7) == 0)
            send_pixel(8'($urandom_range(0, 255)), 1'b0);

         reps = $urandom_range(1, 2);
         repeat (reps) begin
            // Large sprites are cut short: their first pixels carry the
            // right-edge clip and the base limit.
            n = w * h;
            if (n == 0)
               n = 3;
            if (n > MAX_SPRITE_PIXELS)
               n = MAX_SPRITE_PIXELS;
            broken = (n > 1) && ($urandom_range(0, 5) == 0);
            cut    = (n > 1) ? $urandom_range(1, n - 1) : 0;
            for (i = 0; i < n; i++) begin
               r   = $urandom_range(0, 3);
               pix = (r == 0) ? 8'd0 : 8'($urandom_range(1, 255));
               send_pixel(pix, (i == 0) || (broken && i == cut));
            end
            // Trailing pixels past the end of the sprite.
            extra = $urandom_range(0, 3);
            repeat (extra)
               send_pixel(8'($urandom_range(0, 255)), 1'b0);
         end
      end
      no_idle = 1'b0;
   endtask

   // -------------------------------------------------------------------------
   // Sequence
   // -------------------------------------------------------------------------
   initial begin
      reset               = 1'b1;
      psel                = 1'b0;
      penable             = 1'b0;
      pwrite              = 1'b0;
      paddr               = '0;
      pwdata              = '0;
      req_bus.valid       = 1'b0;
      req_bus.pixel       = '0;
      req_bus.first_pixel = 1'b0;
      rsp_bus.ready       = 1'b0;
      // Reset state of our copy.
      set_x        = '0;
      set_y        = '0;
      set_w        = '0;
      set_h        = '0;
      set_offset   = '0;
      set_mirror   = MIRROR_FWD;
      sprite_col   = '0;
      sprite_row   = '0;
      line_base    = '0;
      sprite_ended = 1'b0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(posedge clock);

      test_no_restart();
      test_pixel_extremes();
      test_mirror();
      test_right_clip();
      test_out_of_range();
      test_base_limit();
      test_odd_mirror();
      test_empty_sprite();
      test_backpressure();
      test_random_sprites();

      wait_idle();
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
